// ===== hdl/crss_pkg.sv =====
// ----------------------------------------------------------------------------
// crss_pkg
// Shared constants and controller/datapath interface types for the
// Catmull-Rom segment sampler.
// ----------------------------------------------------------------------------
package crss_pkg;

	localparam int MAX_SAMPLES = 62;
	localparam int KEPT_W      = $clog2(MAX_SAMPLES + 1);
	localparam int T_FRAC      = 24;
	localparam int CNT_W       = $clog2(T_FRAC);
	localparam int H_W         = 40;
	localparam int ACC_W       = H_W + T_FRAC;
	localparam int SPAN_W      = 33;
	localparam logic [SPAN_W-1:0] HALF_STEP = SPAN_W'(32768);

	localparam logic [1:0] SEL_P1     = 2'd0;
	localparam logic [1:0] SEL_SAMPLE = 2'd1;
	localparam logic [1:0] SEL_P2     = 2'd2;

	typedef struct packed {
		logic             load;
		logic             div_init;
		logic             div_step;
		logic             eval_init;
		logic             axis;
		logic             mul_step;
		logic [CNT_W-1:0] bit_idx;
		logic             horner_add;
		logic [1:0]       stage;
		logic             res_store;
		logic             qual_update;
		logic             out_load;
		logic [1:0]       out_sel;
		logic             kept_inc;
		logic             offs_step;
	} cmd_t;

	typedef struct packed {
		logic span_pos;
		logic offs_lt_span;
		logic qualify;
		logic cap_full;
	} sts_t;

endpackage

// ===== hdl/crss_ctrl.sv =====
// ----------------------------------------------------------------------------
// crss_ctrl
// Sequencer: runs the step loop, the bit-serial divide and the Horner
// multiplies, and owns both handshakes.
// ----------------------------------------------------------------------------
module crss_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	output logic           out_valid,
	input  logic           out_ready,
	input  crss_pkg::sts_t sts,
	output crss_pkg::cmd_t cmd
);

	localparam logic [3:0] S_IDLE   = 4'd0;
	localparam logic [3:0] S_P1     = 4'd1;
	localparam logic [3:0] S_LOOP   = 4'd2;
	localparam logic [3:0] S_DIV    = 4'd3;
	localparam logic [3:0] S_EVINIT = 4'd4;
	localparam logic [3:0] S_MUL    = 4'd5;
	localparam logic [3:0] S_ADD    = 4'd6;
	localparam logic [3:0] S_RES    = 4'd7;
	localparam logic [3:0] S_CHK    = 4'd8;
	localparam logic [3:0] S_EMIT   = 4'd9;
	localparam logic [3:0] S_NEXT   = 4'd10;
	localparam logic [3:0] S_FIN    = 4'd11;

	localparam logic [crss_pkg::CNT_W-1:0] CNT_LAST = crss_pkg::CNT_W'(crss_pkg::T_FRAC - 1);

	logic [3:0]                 state_q, state_n;
	logic [crss_pkg::CNT_W-1:0] cnt_q, cnt_n;
	logic [1:0]                 stage_q, stage_n;
	logic                       axis_q, axis_n;
	logic                       out_valid_q;
	logic                       slot_free;

	assign slot_free = !out_valid_q || out_ready;
	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;

	always_comb begin
		state_n = state_q;
		cnt_n   = cnt_q;
		stage_n = stage_q;
		axis_n  = axis_q;
		cmd     = '0;
		cmd.axis    = axis_q;
		cmd.stage   = stage_q;
		cmd.bit_idx = CNT_LAST - cnt_q;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					state_n  = S_P1;
				end
			end
			S_P1: begin
				if (slot_free) begin
					cmd.out_load = 1'b1;
					cmd.out_sel  = crss_pkg::SEL_P1;
					state_n      = sts.span_pos ? S_LOOP : S_FIN;
				end
			end
			S_LOOP: begin
				if (sts.offs_lt_span) begin
					cmd.div_init = 1'b1;
					cnt_n        = '0;
					state_n      = S_DIV;
				end else begin
					state_n = S_FIN;
				end
			end
			S_DIV: begin
				cmd.div_step = 1'b1;
				cnt_n        = cnt_q + 1'b1;
				if (cnt_q == CNT_LAST) begin
					axis_n  = 1'b0;
					state_n = S_EVINIT;
				end
			end
			S_EVINIT: begin
				cmd.eval_init = 1'b1;
				stage_n       = '0;
				cnt_n         = '0;
				state_n       = S_MUL;
			end
			S_MUL: begin
				cmd.mul_step = 1'b1;
				cnt_n        = cnt_q + 1'b1;
				if (cnt_q == CNT_LAST)
					state_n = S_ADD;
			end
			S_ADD: begin
				cmd.horner_add = 1'b1;
				cnt_n          = '0;
				if (stage_q == 2'd2) begin
					state_n = S_RES;
				end else begin
					stage_n = stage_q + 1'b1;
					state_n = S_MUL;
				end
			end
			S_RES: begin
				cmd.res_store = 1'b1;
				state_n       = axis_q ? S_EMIT : S_CHK;
			end
			S_CHK: begin
				cmd.qual_update = sts.qualify;
				if (sts.qualify && !sts.cap_full) begin
					axis_n  = 1'b1;
					state_n = S_EVINIT;
				end else begin
					state_n = S_NEXT;
				end
			end
			S_EMIT: begin
				if (slot_free) begin
					cmd.out_load = 1'b1;
					cmd.out_sel  = crss_pkg::SEL_SAMPLE;
					cmd.kept_inc = 1'b1;
					state_n      = S_NEXT;
				end
			end
			S_NEXT: begin
				cmd.offs_step = 1'b1;
				state_n       = S_LOOP;
			end
			S_FIN: begin
				if (slot_free) begin
					cmd.out_load = 1'b1;
					cmd.out_sel  = crss_pkg::SEL_P2;
					state_n      = S_IDLE;
				end
			end
			default: state_n = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cnt_q       <= '0;
			stage_q     <= '0;
			axis_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_n;
			cnt_q   <= cnt_n;
			stage_q <= stage_n;
			axis_q  <= axis_n;
			if (cmd.out_load)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> (!out_valid_q || out_ready))
		else $error("result overwritten before taken");

	a_accept_to_p1: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> (state_q == S_P1))
		else $error("accept did not start a run");

	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DIV || state_q == S_MUL) |-> (cnt_q <= CNT_LAST))
		else $error("bit counter out of range");

	a_stage_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_ADD) |-> (stage_q <= 2'd2))
		else $error("Horner stage out of range");

endmodule

// ===== hdl/crss_dp.sv =====
// ----------------------------------------------------------------------------
// crss_dp
// Datapath: control points, coefficients, restoring divider for t,
// shift-add Horner multiplier, sample filter and result register.
// ----------------------------------------------------------------------------
module crss_dp (
	input  logic               clk,
	input  logic               arst_n,
	input  crss_pkg::cmd_t     cmd,
	output crss_pkg::sts_t     sts,
	input  logic signed [31:0] pa_x,
	input  logic signed [31:0] pa_y,
	input  logic signed [31:0] pb_x,
	input  logic signed [31:0] pb_y,
	input  logic signed [31:0] pc_x,
	input  logic signed [31:0] pc_y,
	input  logic signed [31:0] pd_x,
	input  logic signed [31:0] pd_y,
	output logic signed [31:0] out_x,
	output logic signed [31:0] out_y,
	output logic               is_final,
	output logic               samples_dropped
);

	localparam int HW = crss_pkg::H_W;
	localparam int AW = crss_pkg::ACC_W;
	localparam int SW = crss_pkg::SPAN_W;
	localparam int TF = crss_pkg::T_FRAC;

	typedef logic signed [HW-1:0] h_t;

	logic signed [31:0] b_x_q, b_y_q, c_x_q, c_y_q;
	h_t                 coef_q [2][4];
	logic [SW-1:0]      span_q, offs_q;
	logic [31:0]        rem_q;
	logic [TF-1:0]      t_q;
	h_t                 h_q;
	logic signed [AW-1:0] acc_q;
	logic signed [31:0] nx_q, ny_q, last_x_q;
	logic               any_q, dropped_q;
	logic [crss_pkg::KEPT_W-1:0] kept_q;

	h_t a0, a1, a2, a3, b0, b1, b2, b3;
	logic signed [SW-1:0] span_s;
	logic [SW-1:0]        rem2;
	logic                 rem_ge;
	logic signed [AW-1:0] acc_nxt;
	h_t                   h_fl, h_half, h_sum;
	logic signed [31:0]   sat_v;

	assign a0 = HW'(pa_x);
	assign a1 = HW'(pb_x);
	assign a2 = HW'(pc_x);
	assign a3 = HW'(pd_x);
	assign b0 = HW'(pa_y);
	assign b1 = HW'(pb_y);
	assign b2 = HW'(pc_y);
	assign b3 = HW'(pd_y);
	assign span_s = SW'(pd_x) - SW'(pa_x);

	assign rem2   = {rem_q, 1'b0};
	assign rem_ge = rem2 >= span_q;

	assign acc_nxt = (acc_q <<< 1) + (t_q[cmd.bit_idx] ? AW'(h_q) : AW'(0));
	assign h_fl    = HW'(acc_q >>> TF);
	assign h_sum   = h_fl + coef_q[cmd.axis][2'd2 - cmd.stage];
	assign h_half  = h_q >>> 1;

	always_comb begin
		if (h_half > HW'(32'sh7fffffff))
			sat_v = 32'sh7fffffff;
		else if (h_half < -HW'(33'sh080000000))
			sat_v = 32'sh80000000;
		else
			sat_v = h_half[31:0];
	end

	assign sts.span_pos     = !span_q[SW-1] && (span_q != '0);
	assign sts.offs_lt_span = offs_q < span_q;
	assign sts.qualify      = (!any_q || (nx_q > last_x_q)) && (nx_q < c_x_q);
	assign sts.cap_full     = kept_q == crss_pkg::KEPT_W'(crss_pkg::MAX_SAMPLES);

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			b_x_q <= pb_x;
			b_y_q <= pb_y;
			c_x_q <= pc_x;
			c_y_q <= pc_y;
			span_q <= span_s;
			offs_q <= '0;
			coef_q[0][0] <= a1 <<< 1;
			coef_q[0][1] <= a2 - a0;
			coef_q[0][2] <= (a0 <<< 1) - 5 * a1 + (a2 <<< 2) - a3;
			coef_q[0][3] <= 3 * (a1 - a2) + a3 - a0;
			coef_q[1][0] <= b1 <<< 1;
			coef_q[1][1] <= b2 - b0;
			coef_q[1][2] <= (b0 <<< 1) - 5 * b1 + (b2 <<< 2) - b3;
			coef_q[1][3] <= 3 * (b1 - b2) + b3 - b0;
		end
		if (cmd.offs_step)
			offs_q <= offs_q + crss_pkg::HALF_STEP;
		if (cmd.div_init)
			rem_q <= offs_q[31:0];
		if (cmd.div_step) begin
			rem_q <= rem_ge ? 32'(rem2 - span_q) : rem2[31:0];
			t_q   <= {t_q[TF-2:0], rem_ge};
		end
		if (cmd.eval_init) begin
			h_q   <= coef_q[cmd.axis][3];
			acc_q <= '0;
		end
		if (cmd.mul_step)
			acc_q <= acc_nxt;
		if (cmd.horner_add) begin
			h_q   <= h_sum;
			acc_q <= '0;
		end
		if (cmd.res_store) begin
			if (cmd.axis)
				ny_q <= sat_v;
			else
				nx_q <= sat_v;
		end
		if (cmd.qual_update)
			last_x_q <= nx_q;
		if (cmd.out_load) begin
			case (cmd.out_sel)
				crss_pkg::SEL_P1: begin
					out_x           <= b_x_q;
					out_y           <= b_y_q;
					is_final        <= 1'b0;
					samples_dropped <= 1'b0;
				end
				crss_pkg::SEL_SAMPLE: begin
					out_x           <= nx_q;
					out_y           <= ny_q;
					is_final        <= 1'b0;
					samples_dropped <= 1'b0;
				end
				default: begin
					out_x           <= c_x_q;
					out_y           <= c_y_q;
					is_final        <= 1'b1;
					samples_dropped <= dropped_q;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			any_q     <= 1'b0;
			dropped_q <= 1'b0;
			kept_q    <= '0;
		end else if (cmd.load) begin
			any_q     <= 1'b0;
			dropped_q <= 1'b0;
			kept_q    <= '0;
		end else begin
			if (cmd.qual_update) begin
				any_q <= 1'b1;
				if (sts.cap_full)
					dropped_q <= 1'b1;
			end
			if (cmd.kept_inc)
				kept_q <= kept_q + 1'b1;
		end
	end

endmodule

// ===== hdl/catmull_rom_segment_sampler_core.sv =====
// ----------------------------------------------------------------------------
// catmull_rom_segment_sampler_core
// Samples one Catmull-Rom segment from four Q16.16 control points.
// ----------------------------------------------------------------------------
// One transaction in yields the segment start, up to MAX_SAMPLES curve
// samples with x rising and below the segment end, then the segment end
// flagged final. A step that keeps no sample tests the step position, runs the
// bit-serial divide that forms t, evaluates x (three shift-add multiplies,
// each followed by an add, plus setup and store), checks and advances. A step
// that emits a sample also evaluates y and emits it, and can wait on output
// stalls. Each segment also takes the accept, the two endpoint results and
// the last step test; the step count is (x3 - x0) / 0.5 rounded up. One
// segment is in work at a time; the next input waits until the final result
// is loaded.
module catmull_rom_segment_sampler_core (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic signed [31:0] pa_x,
	input  logic signed [31:0] pa_y,
	input  logic signed [31:0] pb_x,
	input  logic signed [31:0] pb_y,
	input  logic signed [31:0] pc_x,
	input  logic signed [31:0] pc_y,
	input  logic signed [31:0] pd_x,
	input  logic signed [31:0] pd_y,
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [31:0] out_x,
	output logic signed [31:0] out_y,
	output logic               is_final,
	output logic               samples_dropped
);

	crss_pkg::cmd_t cmd;
	crss_pkg::sts_t sts;

	crss_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	crss_dp u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.sts             (sts),
		.pa_x            (pa_x),
		.pa_y            (pa_y),
		.pb_x            (pb_x),
		.pb_y            (pb_y),
		.pc_x            (pc_x),
		.pc_y            (pc_y),
		.pd_x            (pd_x),
		.pd_y            (pd_y),
		.out_x           (out_x),
		.out_y           (out_y),
		.is_final        (is_final),
		.samples_dropped (samples_dropped)
	);

endmodule

// ===== bench/catmull_rom_segment_sampler_core_tb.sv =====
// ----------------------------------------------------------------------------
// catmull_rom_segment_sampler_core_tb
// Self-checking bench for the Catmull-Rom segment sampler core.
// ----------------------------------------------------------------------------
// Sends directed and random control-point sets through the valid/ready input
// channel, with random idle gaps and output back-pressure. A scoreboard
// predicts the segment start, the kept curve samples and the flagged segment
// end for every accepted transaction and checks each result in order.
// ----------------------------------------------------------------------------
module catmull_rom_segment_sampler_core_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int NUM_RANDOM = 260;
	localparam int IDLE_LIMIT = 60000;
	localparam longint UNIT   = 65536;

	typedef struct {
		logic signed [31:0] ax, ay, bx, by, cx, cy, dx, dy;
	} seg_pts_t;

	typedef struct {
		logic signed [31:0] x;
		logic signed [31:0] y;
		logic               fin;
		logic               drop;
	} curve_pt_t;

	class segment_scoreboard;
		curve_pt_t pending[$];
		int        errors;
		int        checked;
		int        segments;
		int        capped;

		function automatic longint fshr(longint v, int n);
			return v >>> n;
		endfunction

		function automatic longint curve_at(longint p0, longint p1, longint p2, longint p3,
		                                    longint t);
			longint c0, c1, c2, c3, h;
			c0 = 2 * p1;
			c1 = p2 - p0;
			c2 = 2 * p0 - 5 * p1 + 4 * p2 - p3;
			c3 = -p0 + 3 * p1 - 3 * p2 + p3;
			h = c3;
			h = fshr(h * t, crss_pkg::T_FRAC) + c2;
			h = fshr(h * t, crss_pkg::T_FRAC) + c1;
			h = fshr(h * t, crss_pkg::T_FRAC) + c0;
			h = fshr(h, 1);
			if (h > 64'sd2147483647) h = 64'sd2147483647;
			if (h < -64'sd2147483648) h = -64'sd2147483648;
			return h;
		endfunction

		function void note_segment(seg_pts_t s);
			longint    span, offs, t, nx, ny, last_x;
			int        kept;
			bit        any, dropped;
			curve_pt_t r;
			segments++;
			kept = 0;
			any = 0;
			dropped = 0;
			last_x = 0;
			r = '{s.bx, s.by, 1'b0, 1'b0};
			pending.insert(pending.size(), r);
			if (longint'(s.dx) > longint'(s.ax)) begin
				span = longint'(s.dx) - longint'(s.ax);
				for (offs = 0; offs < span; offs += 32768) begin
					t = (offs << crss_pkg::T_FRAC) / span;
					nx = curve_at(s.ax, s.bx, s.cx, s.dx, t);
					if ((!any || nx > last_x) && nx < longint'(s.cx)) begin
						ny = curve_at(s.ay, s.by, s.cy, s.dy, t);
						any = 1;
						last_x = nx;
						if (kept < crss_pkg::MAX_SAMPLES) begin
							r = '{nx[31:0], ny[31:0], 1'b0, 1'b0};
							pending.insert(pending.size(), r);
							kept++;
						end else begin
							dropped = 1;
						end
					end
				end
			end
			if (dropped) capped++;
			r = '{s.cx, s.cy, 1'b1, dropped};
			pending.insert(pending.size(), r);
		endfunction

		function void check_result(curve_pt_t act);
			curve_pt_t e;
			checked++;
			if (pending.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("unexpected result x=%h y=%h fin=%b drop=%b",
						act.x, act.y, act.fin, act.drop);
				return;
			end
			e = pending.pop_front();
			if (e.x !== act.x || e.y !== act.y || e.fin !== act.fin || e.drop !== act.drop) begin
				errors++;
				if (errors <= 10)
					$display("mismatch: expected x=%h y=%h fin=%b drop=%b, got x=%h y=%h fin=%b drop=%b",
						e.x, e.y, e.fin, e.drop, act.x, act.y, act.fin, act.drop);
			end
		endfunction
	endclass

	logic               clk;
	logic               arst_n;
	logic               in_valid;
	logic               in_ready;
	logic signed [31:0] pa_x, pa_y, pb_x, pb_y, pc_x, pc_y, pd_x, pd_y;
	logic               out_valid;
	logic               out_ready;
	logic signed [31:0] out_x, out_y;
	logic               is_final;
	logic               samples_dropped;

	segment_scoreboard sb;
	bit                quiet;
	int                idle_cycles;

	catmull_rom_segment_sampler_core dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.pa_x(pa_x), .pa_y(pa_y), .pb_x(pb_x), .pb_y(pb_y),
		.pc_x(pc_x), .pc_y(pc_y), .pd_x(pd_x), .pd_y(pd_y),
		.out_valid(out_valid), .out_ready(out_ready),
		.out_x(out_x), .out_y(out_y),
		.is_final(is_final), .samples_dropped(samples_dropped)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	function automatic int pick_gap();
		int r;
		if (quiet) return 0;
		r = $urandom_range(0, 99);
		if (r < 60) return 0;
		if (r < 92) return $urandom_range(1, 3);
		return $urandom_range(10, 60);
	endfunction

	function automatic seg_pts_t mk(longint ax, longint ay, longint bx, longint by,
	                                longint cx, longint cy, longint dx, longint dy);
		seg_pts_t s;
		s.ax = 32'(ax); s.ay = 32'(ay); s.bx = 32'(bx); s.by = 32'(by);
		s.cx = 32'(cx); s.cy = 32'(cy); s.dx = 32'(dx); s.dy = 32'(dy);
		return s;
	endfunction

	function automatic seg_pts_t random_segment();
		seg_pts_t s;
		longint   span, x0, x1, x2;
		int       r;
		s.ay = $urandom; s.by = $urandom; s.cy = $urandom; s.dy = $urandom;
		r = $urandom_range(0, 99);
		if (r < 25) begin
			s.ax = $urandom; s.bx = $urandom; s.cx = $urandom;
			s.dx = 32'(s.ax - longint'($urandom_range(0, 32'h7fffffff) %
				(longint'(s.ax) + 64'sd2147483649)));
			return s;
		end
		if (r < 30) span = $urandom_range(30 * UNIT, 40 * UNIT);
		else span = $urandom_range(1, 6 * UNIT);
		x0 = longint'($signed(32'($urandom)));
		if (x0 + span > 64'sd2147483647) x0 = 64'sd2147483647 - span;
		if (r < 45) begin
			x1 = x0 + longint'($urandom_range(0, 32'(2 * span))) - span / 2;
			x2 = x0 + longint'($urandom_range(0, 32'(2 * span))) - span / 2;
		end else begin
			x1 = x0 + $urandom_range(0, 32'(span));
			x2 = x1 + $urandom_range(0, 32'(x0 + span - x1));
		end
		if (x1 > 64'sd2147483647) x1 = 64'sd2147483647;
		if (x2 > 64'sd2147483647) x2 = 64'sd2147483647;
		if (x1 < -64'sd2147483648) x1 = -64'sd2147483648;
		if (x2 < -64'sd2147483648) x2 = -64'sd2147483648;
		s.ax = 32'(x0); s.bx = 32'(x1); s.cx = 32'(x2); s.dx = 32'(x0 + span);
		return s;
	endfunction

	task automatic send_segment(seg_pts_t s);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			in_valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		pa_x = s.ax; pa_y = s.ay; pb_x = s.bx; pb_y = s.by;
		pc_x = s.cx; pc_y = s.cy; pd_x = s.dx; pd_y = s.dy;
		in_valid = 1'b1;
		do @(posedge clk); while (!in_ready);
		sb.note_segment(s);
		@(negedge clk);
	endtask

	task automatic drain_results();
		int        gap;
		curve_pt_t act;
		forever begin
			gap = pick_gap();
			if (gap > 0) begin
				out_ready = 1'b0;
				repeat (gap) @(negedge clk);
			end
			out_ready = 1'b1;
			do @(posedge clk); while (!out_valid);
			act = '{out_x, out_y, is_final, samples_dropped};
			sb.check_result(act);
			@(negedge clk);
		end
	endtask

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("watchdog: no transaction for %0d cycles", IDLE_LIMIT);
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	initial begin
		seg_pts_t dir[$];
		int       wait_cnt;
		sb = new();
		idle_cycles = 0;
		quiet = 0;
		arst_n = 1'b0;
		in_valid = 1'b0;
		out_ready = 1'b0;
		pa_x = 0; pa_y = 0; pb_x = 0; pb_y = 0;
		pc_x = 0; pc_y = 0; pd_x = 0; pd_y = 0;
		repeat (11) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);
		fork
			drain_results();
		join_none

		dir.insert(dir.size(), mk(0, 0, 0, 0, 0, 0, 0, 0));
		dir.insert(dir.size(), mk(64'sd2147483647, -64'sd2147483648, -64'sd2147483648,
			64'sd2147483647, 64'sd2147483647, -64'sd2147483648, -64'sd2147483648,
			64'sd2147483647));
		dir.insert(dir.size(), mk(-1, -1, -1, -1, -1, -1, -1, -1));
		dir.insert(dir.size(), mk(5 * UNIT, 1, 6 * UNIT, 2, 7 * UNIT, 3, 5 * UNIT, 4));
		dir.insert(dir.size(), mk(0, 0, 0, 0, 1, 0, 1, 0));
		dir.insert(dir.size(), mk(0, 0, 0, 0, 32768, 0, 32768, 0));
		dir.insert(dir.size(), mk(0, 0, 0, 0, 32769, 9, 32769, 9));
		dir.insert(dir.size(), mk(0, 0, UNIT, UNIT, 2 * UNIT, 2 * UNIT, 3 * UNIT, 3 * UNIT));
		dir.insert(dir.size(), mk(0, 0, 13 * UNIT, 5 * UNIT, 26 * UNIT, 10 * UNIT,
			40 * UNIT, 15 * UNIT));
		dir.insert(dir.size(), mk(-20 * UNIT, 0, -7 * UNIT, 1, 6 * UNIT, 2, 20 * UNIT, 3));
		dir.insert(dir.size(), mk(0, 0, 3 * UNIT, 0, UNIT, 0, 4 * UNIT, 0));
		dir.insert(dir.size(), mk(0, -64'sd2147483648, UNIT, 64'sd2147483647,
			2 * UNIT, -64'sd2147483648, 3 * UNIT, 64'sd2147483647));
		dir.insert(dir.size(), mk(64'sd2147483647 - 4 * UNIT, 0, -64'sd2147483648, 5,
			64'sd2147483647, 7, 64'sd2147483647, 11));
		dir.insert(dir.size(), mk(-64'sd2147483648, 1, -64'sd2147483648 + UNIT, 2,
			-64'sd2147483648 + 2 * UNIT, 3, -64'sd2147483648 + 3 * UNIT, 4));
		dir.insert(dir.size(), mk(64'sd2147483647 - 3 * UNIT, 0, 64'sd2147483647 - 2 * UNIT, 0,
			64'sd2147483647 - UNIT, 0, 64'sd2147483647, 0));
		dir.insert(dir.size(), mk(0, 0, UNIT, 0, UNIT, 0, 2 * UNIT, 0));
		dir.insert(dir.size(), mk(0, 0, 2 * UNIT, 0, 2 * UNIT, 0, 2 * UNIT, 0));
		foreach (dir[i]) send_segment(dir[i]);

		for (int i = 0; i < NUM_RANDOM; i++) begin
			quiet = (i >= 100 && i < 130);
			send_segment(random_segment());
		end
		in_valid = 1'b0;

		wait_cnt = 0;
		while (sb.pending.size() != 0 && wait_cnt < 200000) begin
			@(negedge clk);
			wait_cnt++;
		end
		repeat (300) @(negedge clk);

		if (sb.pending.size() != 0) begin
			sb.errors++;
			$display("%0d expected results never arrived", sb.pending.size());
		end
		$display("sent %0d segments, checked %0d curve points, %0d segments hit the sample cap",
			sb.segments, sb.checked, sb.capped);
		if (sb.errors == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("%0d mismatches in total", sb.errors);
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

endmodule
